/* sv/spt_pkg.sv */
`default_nettype none
package spt_pkg;

    // window geometry
    localparam int NUM_WINDOWS = 4;
    localparam int DIST_REGS   = 4;
    localparam int ACT_MAX     = (NUM_WINDOWS < DIST_REGS) ? NUM_WINDOWS : DIST_REGS;
    localparam int K_W         = (ACT_MAX > 1) ? $clog2(ACT_MAX) : 1;
    localparam int N_W         = $clog2(ACT_MAX + 1);

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int DIST_W    = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGN_TRANS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_IN_USE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_0      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_2      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_3      = 3'd6;

    localparam logic [7:0] MIN_QUAL_RESET   = 8'd25;
    localparam logic [2:0] WIN_IN_USE_RESET = 3'd1;

    // item operations
    localparam logic OP_SITE   = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // base codes
    localparam logic [2:0] BASE_A = 3'd0;
    localparam logic [2:0] BASE_C = 3'd1;
    localparam logic [2:0] BASE_G = 3'd2;
    localparam logic [2:0] BASE_T = 3'd3;

    localparam logic [3:0] ALLELE_MISSING = 4'd15;
    localparam logic [3:0] ALLELE_REF     = 4'd0;

    // genotype patterns
    localparam logic [1:0] PAT_NONE = 2'd0;
    localparam logic [1:0] PAT_AB   = 2'd1;
    localparam logic [1:0] PAT_BC   = 2'd2;
    localparam logic [1:0] PAT_AC   = 2'd3;

    typedef struct packed {
        logic [7:0]                        min_quality;
        logic                              drop_transitions;
        logic [2:0]                        windows_in_use;
        logic [DIST_REGS-1:0][DIST_W-1:0]  win_dist;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic        informative;
        logic [1:0]  pattern;
        logic [15:0] chrom;
        logic [30:0] pos;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  window_index;
        logic [31:0] count_ab;
        logic [31:0] count_bc;
        logic [31:0] count_ac;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

/* sv/snp_pattern_thinned_counter.sv */
// Three-sample SNP pattern counter with distance thinning.
//
// Input channel: drive the item fields and raise push; the item transfers at a
// clock edge where push is high and full is low. operation 0 evaluates a site,
// operation 1 asks for a report of all active windows.
// Result channel: while empty is low the oldest result sits on the o_ ports and
// transfers at an edge where pop is high. A report gives one result per active
// window in index order, last_of_report set on the final one; sites give none.
// With both queues empty, a report passes the command queue, then the result
// queue, before its first result shows; the rest follow one per cycle while
// pop stays high. Throughput: one site per cycle while no report holds the
// back end; a report holds it until every active window has given its result.
// When the receiver stalls, the two-entry result queue fills, the report
// holds in the back end, and the two-entry command queue then raises full.
// Configuration: write i_cfg_index / i_cfg_data with i_cfg_we, only while idle.
// Reset (synchronous, active low) empties both queues, zeroes all counters and
// forgets the current chromosome and every window's last counted position.
`default_nettype none
module snp_pattern_thinned_counter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [spt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [spt_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_operation,
    input  wire logic [15:0]                   i_chrom_id,
    input  wire logic [30:0]                   i_position,
    input  wire logic [2:0]                    i_ref_base,
    input  wire logic [20:0]                   i_sample_a,
    input  wire logic [20:0]                   i_sample_b,
    input  wire logic [20:0]                   i_sample_c,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [1:0]                         o_window_index,
    output logic [31:0]                        o_count_ab,
    output logic [31:0]                        o_count_bc,
    output logic [31:0]                        o_count_ac,
    output logic                               o_last_of_report
);

    spt_pkg::t_cfg    r_cfg;
    spt_pkg::t_cmd    cmd;
    spt_pkg::t_result res;
    logic             cmd_valid;
    logic             cmd_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_quality      <= spt_pkg::MIN_QUAL_RESET;
            r_cfg.drop_transitions <= 1'b0;
            r_cfg.windows_in_use   <= spt_pkg::WIN_IN_USE_RESET;
            r_cfg.win_dist         <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                spt_pkg::CFG_MIN_QUAL:   r_cfg.min_quality      <= i_cfg_data[7:0];
                spt_pkg::CFG_IGN_TRANS:  r_cfg.drop_transitions <= i_cfg_data[0];
                spt_pkg::CFG_WIN_IN_USE: r_cfg.windows_in_use   <= i_cfg_data[2:0];
                spt_pkg::CFG_WIN_0:      r_cfg.win_dist[0]      <= i_cfg_data;
                spt_pkg::CFG_WIN_1:      r_cfg.win_dist[1]      <= i_cfg_data;
                spt_pkg::CFG_WIN_2:      r_cfg.win_dist[2]      <= i_cfg_data;
                spt_pkg::CFG_WIN_3:      r_cfg.win_dist[3]      <= i_cfg_data;
                default:                 ;
            endcase
        end
    end

    // classify and queue
    spt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .o_full      (full),
        .i_operation (i_operation),
        .i_chrom_id  (i_chrom_id),
        .i_position  (i_position),
        .i_ref_base  (i_ref_base),
        .i_sample_a  (i_sample_a),
        .i_sample_b  (i_sample_b),
        .i_sample_c  (i_sample_c),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // window update and reporting
    spt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .o_result    (res),
        .i_pop       (pop)
    );

    assign o_window_index   = res.window_index;
    assign o_count_ab       = res.count_ab;
    assign o_count_bc       = res.count_bc;
    assign o_count_ac       = res.count_ac;
    assign o_last_of_report = res.last;

endmodule
`default_nettype wire

/* sv/spt_front.sv */
`default_nettype none
module spt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire spt_pkg::t_cfg i_cfg,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic          i_operation,
    input  wire logic [15:0]   i_chrom_id,
    input  wire logic [30:0]   i_position,
    input  wire logic [2:0]    i_ref_base,
    input  wire logic [20:0]   i_sample_a,
    input  wire logic [20:0]   i_sample_b,
    input  wire logic [20:0]   i_sample_c,
    output logic               o_cmd_valid,
    output spt_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_pop
);

    localparam int QD = 2;

    function automatic logic is_transition(input logic [2:0] r, input logic [2:0] a);
        return (r == spt_pkg::BASE_C && a == spt_pkg::BASE_T) ||
               (r == spt_pkg::BASE_T && a == spt_pkg::BASE_C) ||
               (r == spt_pkg::BASE_G && a == spt_pkg::BASE_A) ||
               (r == spt_pkg::BASE_A && a == spt_pkg::BASE_G);
    endfunction

    logic [2:0][20:0] smp;
    logic [2:0][3:0]  geno;
    logic [2:0][2:0]  altb;
    logic [2:0]       s_ok;
    logic [2:0]       s_alt;
    logic             agree;
    logic [2:0]       alt;
    logic             mono;
    spt_pkg::t_cmd    cmd_in;

    assign smp = {i_sample_c, i_sample_b, i_sample_a};

    // per-sample call checks
    always_comb begin
        logic [3:0] a1;
        logic [3:0] a2;
        for (int s = 0; s < 3; s++) begin
            a1       = smp[s][11:8];
            a2       = smp[s][15:12];
            geno[s]  = a1;
            altb[s]  = smp[s][19:17];
            s_alt[s] = (a1 != spt_pkg::ALLELE_REF);
            s_ok[s]  = (smp[s][7:0] >= i_cfg.min_quality) &&
                       (a1 != spt_pkg::ALLELE_MISSING) &&
                       (a2 != spt_pkg::ALLELE_MISSING) &&
                       (a1 == a2) &&
                       (!s_alt[s] || smp[s][16]);
        end
    end

    // ALT base agreement across samples, chosen ALT base and monomorphic check
    always_comb begin
        agree = (!(s_alt[0] && s_alt[1]) || altb[0] == altb[1]) &&
                (!(s_alt[0] && s_alt[2]) || altb[0] == altb[2]) &&
                (!(s_alt[1] && s_alt[2]) || altb[1] == altb[2]);
        priority if (s_alt[0]) alt = altb[0];
        else if (s_alt[1])     alt = altb[1];
        else if (s_alt[2])     alt = altb[2];
        else                   alt = spt_pkg::BASE_A;
        mono = (geno[0] == geno[1]) && (geno[1] == geno[2]);
    end

    // classified command
    always_comb begin
        cmd_in.op          = i_operation;
        cmd_in.chrom       = i_chrom_id;
        cmd_in.pos         = i_position;
        cmd_in.informative = (&s_ok) && agree && !mono &&
                             !(i_cfg.drop_transitions && is_transition(i_ref_base, alt));
        priority if (geno[0] == geno[1]) cmd_in.pattern = spt_pkg::PAT_AB;
        else if (geno[1] == geno[2])     cmd_in.pattern = spt_pkg::PAT_BC;
        else if (geno[0] == geno[2])     cmd_in.pattern = spt_pkg::PAT_AC;
        else                             cmd_in.pattern = spt_pkg::PAT_NONE;
    end

    // command queue toward the back end
    spt_pkg::t_cmd r_q [QD];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          wr, rd;

    assign o_full      = (r_cnt == 2'(QD));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = i_push && !o_full;
    assign rd          = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

`ifndef ASSERT_OFF
    // a lone write grows the queue by one
    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("command queue count did not follow a write");

    // a lone read shrinks the queue by one
    a_cnt_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd && !wr) |=> r_cnt == $past(r_cnt) - 2'd1)
        else $error("command queue count did not follow a read");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QD))
        else $error("command queue overflow");
`endif

endmodule
`default_nettype wire

/* sv/spt_back.sv */
`default_nettype none
module spt_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire spt_pkg::t_cfg i_cfg,
    input  wire logic          i_cmd_valid,
    input  wire spt_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_empty,
    output spt_pkg::t_result   o_result,
    input  wire logic          i_pop
);

    localparam int NW = spt_pkg::NUM_WINDOWS;
    localparam int QD = 2;

    // active window count
    logic [spt_pkg::N_W-1:0] act_n;
    always_comb begin
        if (i_cfg.windows_in_use == 3'd0)
            act_n = spt_pkg::N_W'(1);
        else if (int'(i_cfg.windows_in_use) > spt_pkg::ACT_MAX)
            act_n = spt_pkg::N_W'(spt_pkg::ACT_MAX);
        else
            act_n = spt_pkg::N_W'(i_cfg.windows_in_use);
    end

    // window state
    logic [15:0]       r_prev_chrom;
    logic              r_prev_valid;
    logic [30:0]       r_last_pos [NW];
    logic [NW-1:0]     r_pos_valid;
    logic [31:0]       r_ab [NW];
    logic [31:0]       r_bc [NW];
    logic [31:0]       r_ac [NW];
    logic [spt_pkg::K_W-1:0] r_rep_k;

    logic [NW-1:0][spt_pkg::DIST_W-1:0] win_span;
    logic [NW-1:0] valid_eff;
    logic [NW-1:0] open;
    logic [NW-1:0] n_pos_valid;
    logic          chrom_chg;
    logic          do_site;
    logic          do_count;

    // output queue
    spt_pkg::t_result r_oq [QD];
    logic             r_owp, r_orp;
    logic [1:0]       r_ocnt;
    logic             out_full;
    logic             out_push;
    logic             out_pop;
    spt_pkg::t_result res;
    logic             rep_last;

    assign chrom_chg = !r_prev_valid || (r_prev_chrom != i_cmd.chrom);
    assign do_site   = i_cmd_valid && (i_cmd.op == spt_pkg::OP_SITE);
    assign do_count  = do_site && i_cmd.informative;

    for (genvar w = 0; w < NW; w++) begin : g_win
        if (w < spt_pkg::DIST_REGS) begin : g_d
            assign win_span[w] = i_cfg.win_dist[w];
        end else begin : g_z
            assign win_span[w] = '0;
        end
        // window has elapsed since the last counted site
        assign valid_eff[w]   = r_pos_valid[w] && !chrom_chg;
        assign open[w]        = (w < int'(act_n)) &&
                                (!valid_eff[w] ||
                                 (32'(r_last_pos[w]) + 32'(win_span[w]) <= 32'(i_cmd.pos)));
        assign n_pos_valid[w] = (do_count && open[w]) ? 1'b1 : valid_eff[w];
    end

    // site execution
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_pos_valid  <= '0;
            for (int w = 0; w < NW; w++) begin
                r_ab[w] <= '0;
                r_bc[w] <= '0;
                r_ac[w] <= '0;
            end
        end else if (do_site) begin
            r_pos_valid <= n_pos_valid;
            if (i_cmd.informative) r_prev_valid <= 1'b1;
            for (int w = 0; w < NW; w++) begin
                if (do_count && open[w]) begin
                    unique case (i_cmd.pattern)
                        spt_pkg::PAT_AB:   r_ab[w] <= r_ab[w] + 32'd1;
                        spt_pkg::PAT_BC:   r_bc[w] <= r_bc[w] + 32'd1;
                        spt_pkg::PAT_AC:   r_ac[w] <= r_ac[w] + 32'd1;
                        spt_pkg::PAT_NONE: ;
                        default:           ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_count) begin
            r_prev_chrom <= i_cmd.chrom;
            for (int w = 0; w < NW; w++) begin
                if (open[w]) r_last_pos[w] <= i_cmd.pos;
            end
        end
    end

    // report: one result per active window
    assign out_full = (r_ocnt == 2'(QD));
    assign out_push = i_cmd_valid && (i_cmd.op == spt_pkg::OP_REPORT) && !out_full;
    assign rep_last = (spt_pkg::N_W'(r_rep_k) + spt_pkg::N_W'(1) == act_n);

    always_comb begin
        res.window_index = 2'(r_rep_k);
        res.last         = rep_last;
        res.count_ab     = r_ab[0];
        res.count_bc     = r_bc[0];
        res.count_ac     = r_ac[0];
        for (int w = 1; w < spt_pkg::ACT_MAX; w++) begin
            if (int'(r_rep_k) == w) begin
                res.count_ab = r_ab[w];
                res.count_bc = r_bc[w];
                res.count_ac = r_ac[w];
            end
        end
    end

    assign o_cmd_pop = do_site || (out_push && rep_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_k <= '0;
        end else if (out_push) begin
            r_rep_k <= rep_last ? '0 : r_rep_k + spt_pkg::K_W'(1);
        end
    end

    // output queue
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_oq[r_orp];
    assign out_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_oq[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (out_push) r_owp <= !r_owp;
            if (out_pop)  r_orp <= !r_orp;
            r_ocnt <= r_ocnt + 2'(out_push) - 2'(out_pop);
        end
    end

`ifndef ASSERT_OFF
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'(QD))
        else $error("result queue overflow");

    a_site_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_site |-> !out_push)
        else $error("site transfer produced a result");

    a_rep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> (spt_pkg::N_W'(r_rep_k) < act_n))
        else $error("report window index past active windows");
`endif

endmodule
`default_nettype wire
